/* hdl/assert_macros.svh */
// Assertion macros used by humidity_temperature_correction.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* hdl/htc_pkg.sv */
package htc_pkg;

    localparam int ADC_BITS_DEF = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int CSQ_W      = 24;
    localparam int CLIN_W     = 16;
    localparam int CCONST_W   = 16;
    localparam int RANGE_W    = 7;

    localparam int X_W    = 25;
    localparam int PROD_W = 2 * X_W;
    localparam int SQ_W   = 32;
    localparam int ACC_W  = 58;
    localparam int W_W    = ACC_W - 32;

    localparam logic [15:0] HUM_GAIN    = 16'd50200;
    localparam logic [31:0] HUM_BIAS    = 32'd75;
    localparam logic [31:0] RECIP       = 32'd3581471100;
    localparam int          RECIP_SHIFT = 40;
    localparam logic [8:0]  DIVISOR     = 9'd307;
    localparam logic [23:0] HUM_OFFSET  = 24'd2045065;

    localparam logic signed [RANGE_W-1:0] RANGE_LOW_RST = -7'sd40;
    localparam logic signed [ACC_W-1:0]   ROUND_HALF    = ACC_W'(64'sh8000_0000);

    localparam logic signed [W_W-1:0] TEMP_MAX = 26'sd32767;
    localparam logic signed [W_W-1:0] TEMP_MIN = -26'sd32768;
    localparam logic signed [W_W-1:0] HUM_MAX  = 26'sd65535;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_SQ,
        CFG_TEMP_LIN,
        CFG_TEMP_CONST,
        CFG_HUM_SQ,
        CFG_HUM_LIN,
        CFG_HUM_CONST,
        CFG_RANGE_LOW
    } t_cfg_idx;

endpackage

/* hdl/htc_correct.sv */
module htc_correct (
    input  logic                                  i_clk,
    input  logic [2:0]                            i_en,
    input  logic signed [htc_pkg::X_W-1:0]        i_x,
    input  logic signed [htc_pkg::CSQ_W-1:0]      i_a,
    input  logic signed [htc_pkg::CLIN_W-1:0]     i_b,
    input  logic signed [htc_pkg::CCONST_W-1:0]   i_c,
    output logic signed [htc_pkg::W_W-1:0]        o_w
);
    import htc_pkg::*;

    localparam int BX_W  = CLIN_W + X_W;
    localparam int ASQ_W = CSQ_W + SQ_W + 1;

    logic signed [X_W-1:0]    r_x;
    logic signed [PROD_W-1:0] r_sqf;
    logic signed [BX_W-1:0]   r_bx;
    logic signed [ASQ_W-1:0]  r_asq;
    logic signed [ACC_W-1:0]  r_part;
    logic signed [W_W-1:0]    r_w;

    logic [SQ_W-1:0]         sq;
    logic signed [ACC_W-1:0] acc;

    // The square is never negative, so its Q16 form is a plain slice.
    assign sq  = r_sqf[SQ_W+15:16];
    assign acc = r_part - ACC_W'(r_asq);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x   <= i_x;
            r_sqf <= i_x * i_x;
            r_bx  <= i_b * i_x;
        end
        if (i_en[1]) begin
            r_asq  <= i_a * $signed({1'b0, sq});
            r_part <= (ACC_W'(r_x) <<< 24) - (ACC_W'(r_bx) <<< 8)
                    - (ACC_W'(i_c) <<< 32) + ROUND_HALF;
        end
        if (i_en[2]) begin
            r_w <= acc[ACC_W-1:32];
        end
    end

    assign o_w = r_w;

endmodule

/* hdl/humidity_temperature_correction.sv */
// Converts raw temperature and humidity conversion bytes into corrected Q8 readings,
// subtracting a configured quadratic error from each. One word is accepted per clock
// cycle unless a stalled output has filled the stages. Each word passes through seven
// register stages: the input register, the reciprocal multiply and the remainder
// correction that divide the humidity value by 307, the squaring multiply, the
// coefficient multiply, the final sum and the saturating output register. A stalled
// output only holds the stages behind it once they fill, so empty stages keep taking
// words. The user must write coefficients through the configuration channel only while
// no word is in flight; the block itself does not enforce this.
`include "assert_macros.svh"

module humidity_temperature_correction #(
    parameter int ADC_BITS = htc_pkg::ADC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [htc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [htc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // Fields from bit 0: temp_lsb[7:0], temp_msb[15:8], hum_lsb[23:16], hum_msb[31:24].
    input  logic [31:0]                       i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // Fields from bit 0: temperature_q8[15:0], humidity_q8[31:16].
    output logic [31:0]                       o_m_axis_tdata
);
    import htc_pkg::*;

    localparam int STAGES = 7;
    localparam int LAST   = STAGES - 1;
    localparam int PAD    = 16 - ADC_BITS;
    localparam int T9_W   = 18;

    logic signed [CSQ_W-1:0]    r_t_sq;
    logic signed [CLIN_W-1:0]   r_t_lin;
    logic signed [CCONST_W-1:0] r_t_const;
    logic signed [CSQ_W-1:0]    r_h_sq;
    logic signed [CLIN_W-1:0]   r_h_lin;
    logic signed [CCONST_W-1:0] r_h_const;
    logic signed [RANGE_W-1:0]  r_range;

    logic [STAGES-1:0]      r_vld;
    logic signed [T9_W-1:0] r1_t9;
    logic [31:0]            r1_p;
    logic signed [T9_W-1:0] r2_t9;
    logic [31:0]            r2_p;
    logic [23:0]            r2_q0;
    logic signed [T9_W-1:0] r3_t9;
    logic signed [X_W-1:0]  r3_h16;
    logic [15:0]            r_out_t;
    logic [15:0]            r_out_h;

    logic [STAGES-1:0]       en;
    logic [7:0]              temp_lsb;
    logic [7:0]              temp_msb;
    logic [7:0]              hum_lsb;
    logic [7:0]              hum_msb;
    logic [ADC_BITS-1:0]     code;
    logic [15:0]             code16;
    logic signed [RANGE_W:0] range_m1;
    logic signed [T9_W-1:0]  t9;
    logic [31:0]             p;
    logic [63:0]             prod;
    logic [31:0]             qm;
    logic [31:0]             rem;
    logic                    fix;
    logic [X_W-1:0]          h16;
    logic signed [X_W-1:0]   t16;
    logic signed [W_W-1:0]   w_t;
    logic signed [W_W-1:0]   w_h;
    logic [15:0]             sat_t;
    logic [15:0]             sat_h;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_sq    <= '0;
            r_t_lin   <= '0;
            r_t_const <= '0;
            r_h_sq    <= '0;
            r_h_lin   <= '0;
            r_h_const <= '0;
            r_range   <= RANGE_LOW_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TEMP_SQ:    r_t_sq    <= i_cfg_data[CSQ_W-1:0];
                CFG_TEMP_LIN:   r_t_lin   <= i_cfg_data[CLIN_W-1:0];
                CFG_TEMP_CONST: r_t_const <= i_cfg_data[CCONST_W-1:0];
                CFG_HUM_SQ:     r_h_sq    <= i_cfg_data[CSQ_W-1:0];
                CFG_HUM_LIN:    r_h_lin   <= i_cfg_data[CLIN_W-1:0];
                CFG_HUM_CONST:  r_h_const <= i_cfg_data[CCONST_W-1:0];
                CFG_RANGE_LOW:  r_range   <= i_cfg_data[RANGE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        en[LAST] = !r_vld[LAST] || i_m_axis_tready;
        for (int k = LAST - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_s_axis_tready = en[0];
    assign o_m_axis_tvalid = r_vld[LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign temp_lsb = i_s_axis_tdata[7:0];
    assign temp_msb = i_s_axis_tdata[15:8];
    assign hum_lsb  = i_s_axis_tdata[23:16];
    assign hum_msb  = i_s_axis_tdata[31:24];

    // The humidity division by 307 is done on a positive dividend: the bias of 75 moves
    // the offset onto a whole multiple of the divisor, which is taken off again later.
    assign code     = ADC_BITS'({hum_msb, hum_lsb} >> PAD);
    assign code16   = 16'(code) << PAD;
    assign p        = (32'(code16) * 32'(HUM_GAIN)) + HUM_BIAS;
    assign range_m1 = {r_range[RANGE_W-1], r_range} - 8'sd1;
    assign t9       = $signed({2'b00, temp_msb, temp_lsb}) + $signed({range_m1, 9'd0});

    assign prod = 64'(r1_p) * 64'(RECIP);
    assign qm   = 32'(r2_q0) * 32'(DIVISOR);
    assign rem  = r2_p - qm;
    assign fix  = (rem >= 32'(DIVISOR));
    assign h16  = X_W'({1'b0, r2_q0}) + X_W'(fix) - X_W'(HUM_OFFSET);

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_t9 <= t9;
            r1_p  <= p;
        end
        if (en[1]) begin
            r2_t9 <= r1_t9;
            r2_p  <= r1_p;
            r2_q0 <= prod[RECIP_SHIFT+23:RECIP_SHIFT];
        end
        if (en[2]) begin
            r3_t9  <= r2_t9;
            r3_h16 <= $signed(h16);
        end
    end

    assign t16 = $signed({r3_t9, 7'd0});

    htc_correct u_corr_temp (
        .i_clk (i_clk),
        .i_en  (en[5:3]),
        .i_x   (t16),
        .i_a   (r_t_sq),
        .i_b   (r_t_lin),
        .i_c   (r_t_const),
        .o_w   (w_t)
    );

    htc_correct u_corr_hum (
        .i_clk (i_clk),
        .i_en  (en[5:3]),
        .i_x   (r3_h16),
        .i_a   (r_h_sq),
        .i_b   (r_h_lin),
        .i_c   (r_h_const),
        .o_w   (w_h)
    );

    always_comb begin
        if (w_t > TEMP_MAX) begin
            sat_t = TEMP_MAX[15:0];
        end else if (w_t < TEMP_MIN) begin
            sat_t = TEMP_MIN[15:0];
        end else begin
            sat_t = w_t[15:0];
        end
        if (w_h < 0) begin
            sat_h = '0;
        end else if (w_h > HUM_MAX) begin
            sat_h = HUM_MAX[15:0];
        end else begin
            sat_h = w_h[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[LAST]) begin
            r_out_t <= sat_t;
            r_out_h <= sat_h;
        end
    end

    assign o_m_axis_tdata = {r_out_h, r_out_t};

    `HTC_ASSERT_SAME(a_ready_when_out_empty, i_clk, i_rst_n, !r_vld[LAST], o_s_axis_tready)
    `HTC_ASSERT_SAME(a_full_stall_blocks_input, i_clk, i_rst_n, (&r_vld) && !i_m_axis_tready, !o_s_axis_tready)
    `HTC_ASSERT_NEXT(a_accept_fills_first_stage, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, r_vld[0])

endmodule

/* bench/tb_humidity_temperature_correction.sv */
`timescale 1ns / 1ps

module tb_humidity_temperature_correction;
    import htc_pkg::*;

    localparam int ADC_BITS = ADC_BITS_DEF;
    localparam int LATENCY = 7;
    localparam int HOLD_CYCLES = 60;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PHASES = 9;
    localparam int READINGS_PER_PHASE = 210;
    localparam int MAX_REPORTS = 40;
    localparam int DIR_ROWS = 38;

    // Humidity scaling: V = code * 5.02 / 2^ADC_BITS, RH = (V - 0.958) / 0.0307.
    localparam longint VOLT_GAIN = 50200;
    localparam longint VOLT_OFFSET = 9580;
    localparam longint RH_DIVISOR = 307;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    typedef struct packed {
        logic [15:0] humidity_q8;
        logic [15:0] temperature_q8;
    } t_reading;

    typedef enum logic {
        ROW_READING,
        ROW_WRITE
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [2:0]  index;
        logic [23:0] value;
        logic [31:0] word;
        logic        typed;
        t_reading    result;
    } t_dir_row;

    typedef enum {
        PICK_ZERO,
        PICK_MAX,
        PICK_MIN,
        PICK_SMALL,
        PICK_ANY
    } t_pick;

    // Reading words are {hum_msb, hum_lsb, temp_msb, temp_lsb}; results are
    // {humidity, temperature}.
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        '{ROW_READING, '0, '0, 32'h0000_0000, 1'b1, '{16'h0000, 16'hD700}},
        '{ROW_READING, '0, '0, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_READING, '0, '0, 32'h8040_0180, 1'b0, '0},
        '{ROW_READING, '0, '0, 32'h55AA_55AA, 1'b0, '0},
        '{ROW_READING, '0, '0, 32'hAA55_AA55, 1'b0, '0},
        '{ROW_READING, '0, '0, 32'h003F_0000, 1'b1, '{16'h0000, 16'hD700}},
        '{ROW_READING, '0, '0, 32'h3100_1020, 1'b0, '0},
        '{ROW_READING, '0, '0, 32'h30C0_2000, 1'b0, '0},
        '{ROW_WRITE, CFG_TEMP_CONST, 24'hA5_8000, '0, 1'b0, '0},
        '{ROW_WRITE, CFG_HUM_CONST, 24'h5A_8000, '0, 1'b0, '0},
        '{ROW_READING, '0, '0, 32'hFFC0_FFFF, 1'b1, '{16'hFFFF, 16'h7FFF}},
        '{ROW_WRITE, CFG_RANGE_LOW, 24'h00_0040, '0, 1'b0, '0},
        '{ROW_WRITE, CFG_TEMP_CONST, 24'h00_7FFF, '0, 1'b0, '0},
        '{ROW_READING, '0, '0, 32'h0000_0000, 1'b0, '0},
        '{ROW_WRITE, CFG_RANGE_LOW, 24'hFF_FF3F, '0, 1'b0, '0},
        '{ROW_WRITE, CFG_TEMP_CONST, 24'h00_0000, '0, 1'b0, '0},
        '{ROW_WRITE, CFG_HUM_CONST, 24'h00_0000, '0, 1'b0, '0},
        '{ROW_READING, '0, '0, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_WRITE, CFG_RANGE_LOW, 24'h00_0000, '0, 1'b0, '0},
        '{ROW_READING, '0, '0, 32'h0000_0000, 1'b1, '{16'h0000, 16'hFF00}},
        '{ROW_WRITE, CFG_TEMP_SQ, 24'h7F_FFFF, '0, 1'b0, '0},
        '{ROW_WRITE, CFG_TEMP_LIN, 24'h00_7FFF, '0, 1'b0, '0},
        '{ROW_WRITE, CFG_HUM_SQ, 24'h80_0000, '0, 1'b0, '0},
        '{ROW_WRITE, CFG_HUM_LIN, 24'hFF_8000, '0, 1'b0, '0},
        '{ROW_READING, '0, '0, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_READING, '0, '0, 32'h8000_8000, 1'b0, '0},
        '{ROW_READING, '0, '0, 32'h0000_0000, 1'b0, '0},
        '{ROW_READING, '0, '0, 32'h6400_1234, 1'b0, '0},
        '{ROW_WRITE, CFG_TEMP_SQ, 24'h80_0000, '0, 1'b0, '0},
        '{ROW_WRITE, CFG_TEMP_LIN, 24'h00_8000, '0, 1'b0, '0},
        '{ROW_WRITE, CFG_HUM_SQ, 24'h7F_FFFF, '0, 1'b0, '0},
        '{ROW_WRITE, CFG_HUM_LIN, 24'h00_7FFF, '0, 1'b0, '0},
        '{ROW_WRITE, CFG_RANGE_LOW, 24'h00_005D, '0, 1'b0, '0},
        '{ROW_READING, '0, '0, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_READING, '0, '0, 32'h8000_8000, 1'b0, '0},
        '{ROW_READING, '0, '0, 32'h0000_0000, 1'b0, '0},
        '{ROW_WRITE, CFG_IDX_SPARE, 24'hFF_FFFF, '0, 1'b0, '0},
        '{ROW_READING, '0, '0, 32'h9C5E_4B21, 1'b0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_s_axis_tvalid = 1'b0;
    logic o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;

    longint temp_sq_coeff = 0;
    longint temp_lin_coeff = 0;
    longint temp_const_coeff = 0;
    longint hum_sq_coeff = 0;
    longint hum_lin_coeff = 0;
    longint hum_const_coeff = 0;
    longint range_floor = -40;

    t_reading expected_readings[$];
    t_reading got_reading;
    t_reading want_reading;
    int mismatches = 0;
    int unsigned cycle_count = 0;
    bit hold_req = 1'b0;
    bit quiet = 1'b0;

    humidity_temperature_correction DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Subtracts A*x*x + B*x + C from a Q16 value and rounds the result half up to Q8.
    function automatic longint apply_correction(input longint x16, input longint a,
                                                input longint b, input longint c);
        longint sq;
        longint err;
        longint val;
        sq = (x16 * x16) >>> 16;
        err = a * sq + b * x16 * 256 + c * (longint'(1) <<< 32);
        val = x16 * (longint'(1) <<< 24) - err;
        return (val + (longint'(1) <<< 31)) >>> 32;
    endfunction

    function automatic t_reading predict_reading(input logic [31:0] word);
        longint tl;
        longint tm;
        longint hl;
        longint hm;
        longint code;
        longint num;
        longint den;
        longint h16;
        longint tq;
        longint hq;
        t_reading r;
        tl = word[7:0];
        tm = word[15:8];
        hl = word[23:16];
        hm = word[31:24];
        tq = apply_correction((tm * 256 + (range_floor - 1) * 512 + tl) * 128,
                              temp_sq_coeff, temp_lin_coeff, temp_const_coeff);
        if (tq > 32767) begin
            tq = 32767;
        end
        if (tq < -32768) begin
            tq = -32768;
        end
        code = (hm << (ADC_BITS - 8)) | (hl >> (16 - ADC_BITS));
        num = (code * VOLT_GAIN - VOLT_OFFSET * (longint'(1) << ADC_BITS)) * 65536;
        den = RH_DIVISOR * (longint'(1) << ADC_BITS);
        if (num < 0) begin
            h16 = -((-num + den - 1) / den);
        end else begin
            h16 = num / den;
        end
        hq = apply_correction(h16, hum_sq_coeff, hum_lin_coeff, hum_const_coeff);
        if (hq < 0) begin
            hq = 0;
        end
        if (hq > 65535) begin
            hq = 65535;
        end
        r.temperature_q8 = tq[15:0];
        r.humidity_q8 = hq[15:0];
        return r;
    endfunction

    function automatic logic [23:0] pick_coeff(input int width, input t_pick mode);
        longint lim;
        longint v;
        logic [23:0] mask;
        lim = longint'(1) << (width - 1);
        mask = 24'((longint'(1) << width) - 1);
        case (mode)
            PICK_ZERO: v = 0;
            PICK_MAX: v = lim - 1;
            PICK_MIN: v = -lim;
            PICK_SMALL: begin
                if (width == RANGE_W) begin
                    v = -longint'($urandom_range(0, 40));
                end else begin
                    v = longint'($urandom_range(0, 2 * (lim >> 6))) - (lim >> 6);
                end
            end
            default: v = longint'($urandom);
        endcase
        return (24'($urandom) & ~mask) | (24'(v) & mask);
    endfunction

    task automatic write_register(input logic [2:0] index, input logic [23:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (index)
            CFG_TEMP_SQ: temp_sq_coeff = longint'(signed'(value[23:0]));
            CFG_TEMP_LIN: temp_lin_coeff = longint'(signed'(value[15:0]));
            CFG_TEMP_CONST: temp_const_coeff = longint'(signed'(value[15:0]));
            CFG_HUM_SQ: hum_sq_coeff = longint'(signed'(value[23:0]));
            CFG_HUM_LIN: hum_lin_coeff = longint'(signed'(value[15:0]));
            CFG_HUM_CONST: hum_const_coeff = longint'(signed'(value[15:0]));
            CFG_RANGE_LOW: range_floor = longint'(signed'(value[6:0]));
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic send_reading(input logic [31:0] word, input bit typed,
                                input t_reading typed_result);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= word;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        expected_readings.push_back(typed ? typed_result : predict_reading(word));
        @(negedge i_clk);
    endtask

    task automatic drain_pipeline();
        i_s_axis_tvalid <= 1'b0;
        while (expected_readings.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (LATENCY + 3) @(negedge i_clk);
    endtask

    // The receiver stalls in short random bursts, and once holds off long enough for
    // the pipeline to fill and push back on the sender.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                i_m_axis_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_reading = o_m_axis_tdata;
            if (expected_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: result word expected none actual %h", $time, got_reading);
                end
            end else begin
                want_reading = expected_readings.pop_front();
                if (got_reading.temperature_q8 !== want_reading.temperature_q8) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: temperature_q8 expected %0d actual %0d", $time,
                                 $signed(want_reading.temperature_q8),
                                 $signed(got_reading.temperature_q8));
                    end
                end
                if (got_reading.humidity_q8 !== want_reading.humidity_q8) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: humidity_q8 expected %0d actual %0d", $time,
                                 want_reading.humidity_q8, got_reading.humidity_q8);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_humidity_temperature_correction failed");
            $finish;
        end
    end

    initial begin
        bit writing;
        t_pick mode;
        logic [31:0] word;
        writing = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int row = 0; row < DIR_ROWS; row++) begin
            if (DIRECTED[row].kind == ROW_WRITE) begin
                if (!writing) begin
                    drain_pipeline();
                    writing = 1'b1;
                end
                write_register(DIRECTED[row].index, DIRECTED[row].value);
            end else begin
                if (writing) begin
                    i_cfg_valid <= 1'b0;
                    writing = 1'b0;
                end
                send_reading(DIRECTED[row].word, DIRECTED[row].typed, DIRECTED[row].result);
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_pipeline();
            quiet = (ph == RANDOM_PHASES - 1);
            for (int idx = CFG_TEMP_SQ; idx <= CFG_RANGE_LOW; idx++) begin
                case (ph)
                    0: mode = (idx == CFG_RANGE_LOW) ? PICK_SMALL : PICK_ZERO;
                    1: mode = PICK_MAX;
                    2: mode = PICK_MIN;
                    default: begin
                        case ($urandom_range(0, 5))
                            0: mode = PICK_MAX;
                            1: mode = PICK_MIN;
                            2, 3: mode = PICK_SMALL;
                            default: mode = PICK_ANY;
                        endcase
                    end
                endcase
                case (idx)
                    CFG_TEMP_SQ, CFG_HUM_SQ: write_register(3'(idx), pick_coeff(CSQ_W, mode));
                    CFG_RANGE_LOW: write_register(3'(idx), pick_coeff(RANGE_W, mode));
                    default: write_register(3'(idx), pick_coeff(CLIN_W, mode));
                endcase
            end
            if (ph == 3) begin
                write_register(CFG_IDX_SPARE, 24'($urandom));
            end
            i_cfg_valid <= 1'b0;
            if (ph == 2) begin
                hold_req = 1'b1;
            end
            for (int n = 0; n < READINGS_PER_PHASE; n++) begin
                for (int f = 0; f < 4; f++) begin
                    case ($urandom_range(0, 15))
                        0: word[8*f +: 8] = 8'h00;
                        1: word[8*f +: 8] = 8'hFF;
                        default: word[8*f +: 8] = 8'($urandom);
                    endcase
                end
                send_reading(word, 1'b0, '0);
            end
        end

        drain_pipeline();
        if (mismatches == 0) begin
            $display("tb_humidity_temperature_correction passed");
        end else begin
            $display("tb_humidity_temperature_correction failed");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/htc_pkg.sv
hdl/htc_correct.sv
hdl/humidity_temperature_correction.sv
bench/tb_humidity_temperature_correction.sv
